@@ rtl/core/swr_pkg.sv @@
// Shared constants and codes for the stop-and-wait receiver.
package swr_pkg;

  // Header size that every datagram carries ahead of its payload
  localparam logic [15:0] HEADER_BYTES = 16'd12;

  // Field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned FLAGS_W  = 5;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Flag bit positions
  localparam int unsigned FLAG_BIT_PSH  = 2;
  localparam int unsigned FLAG_BIT_LAST = 3;
  localparam logic [FLAGS_W-1:0] FLAGS_FIN_ONLY = 5'b10000;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_START   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PACKET  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

  // Reply kinds
  localparam logic [KIND_W-1:0] REPLY_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] REPLY_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] REPLY_FIN_ACK = 2'd2;
  localparam logic [KIND_W-1:0] REPLY_FIN     = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_RECEIVING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE_LAST = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MTU_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd2;

  // Configuration reset values
  localparam logic [15:0] MTU_BYTES_RST    = 16'd1500;
  localparam logic [31:0] BUFFER_BYTES_RST = 32'd65536;
  localparam logic [15:0] RETRY_LIMIT_RST  = 16'd3;

endpackage

@@ rtl/core/swr_channels.sv @@
// Channel interfaces of the stop-and-wait receiver: packet events, results, config writes.
interface swr_in_if import swr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                source_matches;
  logic [15:0]         packet_bytes;
  logic [15:0]         length_field;
  logic                checksum_ok;
  logic [FLAGS_W-1:0]  flags;
  logic [31:0]         seq_num;

  modport source (output valid, action, source_matches, packet_bytes, length_field,
                  checksum_ok, flags, seq_num, input ready);
  modport sink (input valid, action, source_matches, packet_bytes, length_field,
                checksum_ok, flags, seq_num, output ready);
endinterface

interface swr_out_if import swr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   reply_kind;
  logic [31:0]         reply_seq;
  logic                write_enable;
  logic [31:0]         write_offset;
  logic [15:0]         write_length;
  logic [STATUS_W-1:0] status;
  logic [31:0]         byte_total;

  modport source (output valid, reply_kind, reply_seq, write_enable, write_offset,
                  write_length, status, byte_total, input ready);
  modport sink (input valid, reply_kind, reply_seq, write_enable, write_offset,
                write_length, status, byte_total, output ready);
endinterface

interface swr_cfg_if import swr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/stop_and_wait_receiver.sv @@
// Stop-and-wait receiver top level: header checks, reply choice and buffer placement.
//
// Usage:
//   in_ch   carries one event per transaction: start, packet arrived (with header
//           facts) or timeout tick. out_ch returns exactly one result per event:
//           reply kind and sequence, buffer write enable/offset/length, status and
//           running byte total. cfg_ch writes mtu_bytes, buffer_bytes and the retry
//           limit by index; it is always ready and must only be used while idle.
//   Path:   a result passes the input register, then the decision stage that updates
//           state and loads the output register. Throughput: one event per cycle
//           while out_ch does not stall. The offset multiply (sequence times payload
//           stride) and header sanity checks sit in front of the input register;
//           order checks, clamping and state update sit in front of the output
//           register, so consecutive events see each other's state directly.
//   Reset:  config returns to 1500 / 65536 / 3, the reception is idle, last
//           sequence is all ones, counters clear, both stages empty.
//   Stall:  with out_ch.ready low the result holds; one more event may be taken
//           into the input register, then in_ch.ready drops until out_ch drains.
module stop_and_wait_receiver import swr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  swr_in_if.sink    in_ch,
  swr_out_if.source out_ch,
  swr_cfg_if.sink   cfg_ch
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_RECV  = 2'd2;

  // Configuration
  logic [15:0] mtu_r;
  logic [31:0] buffer_r;
  logic [15:0] retry_limit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r         <= MTU_BYTES_RST;
      buffer_r      <= BUFFER_BYTES_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MTU_BYTES:    mtu_r         <= cfg_ch.data[15:0];
        CFG_BUFFER_BYTES: buffer_r      <= cfg_ch.data;
        CFG_RETRY_LIMIT:  retry_limit_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic s1_valid_r;
  logic out_valid_r;
  logic out_free;
  logic adv;
  logic in_acc;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Input stage: header sanity and payload offset
  logic [15:0] stride;
  logic [31:0] off_c;
  logic        basic_c;

  assign stride  = (mtu_r > HEADER_BYTES) ? (mtu_r - HEADER_BYTES) : 16'd0;
  assign off_c   = in_ch.seq_num * {16'd0, stride};
  assign basic_c = (in_ch.packet_bytes >= HEADER_BYTES) && in_ch.checksum_ok &&
                   (in_ch.length_field == in_ch.packet_bytes - HEADER_BYTES);

  logic [ACTION_W-1:0] s1_action_r;
  logic                s1_src_ok_r;
  logic                s1_basic_r;
  logic [15:0]         s1_len_r;
  logic [FLAGS_W-1:0]  s1_flags_r;
  logic [31:0]         s1_seq_r;
  logic [31:0]         s1_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_ch.action;
      s1_src_ok_r <= in_ch.source_matches;
      s1_basic_r  <= basic_c;
      s1_len_r    <= in_ch.length_field;
      s1_flags_r  <= in_ch.flags;
      s1_seq_r    <= in_ch.seq_num;
      s1_off_r    <= off_c;
    end
  end

  // Reception state
  logic [1:0]  phase_r,    phase_nxt;
  logic [31:0] last_seq_r, last_seq_nxt;
  logic [31:0] acc_r,      acc_nxt;
  logic [15:0] try_r,      try_nxt;

  // Decision stage
  logic [KIND_W-1:0]   kind_nxt;
  logic [31:0]         rseq_nxt;
  logic                we_nxt;
  logic [31:0]         woff_nxt;
  logic [15:0]         wlen_nxt;
  logic [STATUS_W-1:0] st_nxt;

  logic [15:0] try_inc;
  logic        gave_up;
  logic [32:0] sum;
  logic        over;
  logic [31:0] acc_sat;
  logic        in_order;
  logic        data_flag;
  logic [32:0] end_pos;
  logic [31:0] room;

  assign try_inc   = try_r + 16'd1;
  assign gave_up   = try_inc >= retry_limit_r;
  assign sum       = {1'b0, acc_r} + {17'd0, s1_len_r};
  assign over      = sum > {1'b0, buffer_r};
  assign acc_sat   = sum[32] ? '1 : sum[31:0];
  assign in_order  = s1_seq_r == (last_seq_r + 32'd1);
  assign data_flag = s1_flags_r[FLAG_BIT_PSH] || s1_flags_r[FLAG_BIT_LAST];
  assign end_pos   = {1'b0, s1_off_r} + {17'd0, s1_len_r};
  assign room      = buffer_r - s1_off_r;

  always_comb begin
    kind_nxt     = REPLY_NONE;
    rseq_nxt     = 32'd0;
    we_nxt       = 1'b0;
    woff_nxt     = 32'd0;
    wlen_nxt     = 16'd0;
    st_nxt       = ST_RECEIVING;
    phase_nxt    = phase_r;
    last_seq_nxt = last_seq_r;
    acc_nxt      = acc_r;
    try_nxt      = try_r;

    priority if (s1_action_r == ACT_START) begin
      phase_nxt    = PH_FIRST;
      last_seq_nxt = '1;
      acc_nxt      = 32'd0;
      try_nxt      = 16'd0;
    end else if (s1_action_r == ACT_UNUSED || phase_r == PH_IDLE) begin
      st_nxt = (phase_r == PH_IDLE) ? ST_IDLE : ST_RECEIVING;
    end else if (s1_action_r == ACT_TIMEOUT) begin
      // timeouts only count once the first packet has arrived
      if (phase_r == PH_RECV) begin
        try_nxt = try_inc;
        if (gave_up) begin
          phase_nxt = PH_IDLE;
          st_nxt    = ST_EXHAUSTED;
        end
      end
    end else if (!s1_src_ok_r) begin
      kind_nxt = REPLY_FIN;
    end else if (s1_basic_r && s1_flags_r == FLAGS_FIN_ONLY) begin
      kind_nxt  = REPLY_FIN_ACK;
      phase_nxt = PH_IDLE;
      st_nxt    = ST_CLOSED;
    end else if (!s1_basic_r || !data_flag) begin
      try_nxt = try_inc;
      if (gave_up) begin
        phase_nxt = PH_IDLE;
        st_nxt    = ST_EXHAUSTED;
      end
    end else if (phase_r == PH_FIRST) begin
      // first packet lands at offset 0 whatever its sequence number
      try_nxt      = 16'd0;
      we_nxt       = 1'b1;
      wlen_nxt     = ({16'd0, s1_len_r} < buffer_r) ? s1_len_r : buffer_r[15:0];
      acc_nxt      = acc_sat;
      last_seq_nxt = s1_seq_r;
      kind_nxt     = REPLY_ACK;
      rseq_nxt     = s1_seq_r;
      priority if (over) begin
        phase_nxt = PH_IDLE;
        st_nxt    = ST_OVERFLOW;
      end else if (s1_flags_r[FLAG_BIT_LAST]) begin
        phase_nxt = PH_IDLE;
        st_nxt    = ST_DONE_LAST;
      end else begin
        phase_nxt = PH_RECV;
      end
    end else begin
      try_nxt  = 16'd0;
      kind_nxt = REPLY_ACK;
      if (!in_order) begin
        rseq_nxt = last_seq_r;
      end else begin
        we_nxt   = 1'b1;
        woff_nxt = s1_off_r;
        priority if (s1_off_r >= buffer_r) begin
          wlen_nxt = 16'd0;
        end else if (end_pos > {1'b0, buffer_r}) begin
          wlen_nxt = room[15:0];
        end else begin
          wlen_nxt = s1_len_r;
        end
        acc_nxt      = acc_sat;
        last_seq_nxt = s1_seq_r;
        rseq_nxt     = s1_seq_r;
        priority if (s1_flags_r[FLAG_BIT_LAST]) begin
          phase_nxt = PH_IDLE;
          st_nxt    = ST_DONE_LAST;
        end else if (over) begin
          phase_nxt = PH_IDLE;
          st_nxt    = ST_OVERFLOW;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      last_seq_r <= '1;
      acc_r      <= 32'd0;
      try_r      <= 16'd0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      last_seq_r <= last_seq_nxt;
      acc_r      <= acc_nxt;
      try_r      <= try_nxt;
    end
  end

  // Output register
  logic [KIND_W-1:0]   out_kind_r;
  logic [31:0]         out_rseq_r;
  logic                out_we_r;
  logic [31:0]         out_woff_r;
  logic [15:0]         out_wlen_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [31:0]         out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r   <= kind_nxt;
      out_rseq_r   <= rseq_nxt;
      out_we_r     <= we_nxt;
      out_woff_r   <= woff_nxt;
      out_wlen_r   <= wlen_nxt;
      out_status_r <= st_nxt;
      out_total_r  <= acc_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.reply_kind   = out_kind_r;
  assign out_ch.reply_seq    = out_rseq_r;
  assign out_ch.write_enable = out_we_r;
  assign out_ch.write_offset = out_woff_r;
  assign out_ch.write_length = out_wlen_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.byte_total   = out_total_r;

  // Checks
  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_action_r == ACT_START) |=> (phase_r == PH_FIRST && acc_r == 32'd0))
    else $error("start transaction did not open a clean reception");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (st_nxt == ST_DONE_LAST || st_nxt == ST_OVERFLOW ||
             st_nxt == ST_CLOSED || st_nxt == ST_EXHAUSTED)) |=> (phase_r == PH_IDLE))
    else $error("terminal status reported but reception still active");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  a_write_is_acked: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && we_nxt) |=> (out_kind_r == REPLY_ACK && out_rseq_r == last_seq_r))
    else $error("stored payload without a matching ACK");

endmodule

@@ bench/tb_stop_and_wait_receiver.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the stop-and-wait receiver: directed and random events vs. a predictor.
module tb_stop_and_wait_receiver;
  import swr_pkg::*;

  localparam int unsigned LATENCY          = 2;
  localparam int unsigned SETTLE_CYCLES    = LATENCY + 4;
  localparam int unsigned STALL_LIMIT      = 3000;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned RANDOM_PER_PHASE = 140;
  localparam int unsigned LONG_RUN_PACKETS = 60;
  localparam int unsigned MAX_SHOWN        = 200;
  localparam logic [15:0] MAX_PAYLOAD      = 16'd65523;

  localparam int unsigned FLAG_BIT_SYN = 0;
  localparam int unsigned FLAG_BIT_ACK = 1;
  localparam logic [FLAGS_W-1:0] FL_SYN  = FLAGS_W'(1 << FLAG_BIT_SYN);
  localparam logic [FLAGS_W-1:0] FL_ACK  = FLAGS_W'(1 << FLAG_BIT_ACK);
  localparam logic [FLAGS_W-1:0] FL_PSH  = FLAGS_W'(1 << FLAG_BIT_PSH);
  localparam logic [FLAGS_W-1:0] FL_LAST = FLAGS_W'(1 << FLAG_BIT_LAST);

  typedef enum logic [1:0] {RX_IDLE, RX_FIRST, RX_ACTIVE} rx_phase_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                source_matches;
    logic [15:0]         packet_bytes;
    logic [15:0]         length_field;
    logic                checksum_ok;
    logic [FLAGS_W-1:0]  flags;
    logic [31:0]         seq_num;
  } rx_event_t;

  typedef struct packed {
    logic [KIND_W-1:0]   reply_kind;
    logic [31:0]         reply_seq;
    logic                write_enable;
    logic [31:0]         write_offset;
    logic [15:0]         write_length;
    logic [STATUS_W-1:0] status;
    logic [31:0]         byte_total;
  } rx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // driven at the falling edge only
  logic                 in_valid  = 1'b0;
  rx_event_t            in_item   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MTU_BYTES;
  logic [31:0]          cfg_data  = '0;

  swr_in_if  in_ch ();
  swr_out_if out_ch ();
  swr_cfg_if cfg_ch ();

  assign in_ch.valid          = in_valid;
  assign in_ch.action         = in_item.action;
  assign in_ch.source_matches = in_item.source_matches;
  assign in_ch.packet_bytes   = in_item.packet_bytes;
  assign in_ch.length_field   = in_item.length_field;
  assign in_ch.checksum_ok    = in_item.checksum_ok;
  assign in_ch.flags          = in_item.flags;
  assign in_ch.seq_num        = in_item.seq_num;
  assign out_ch.ready         = out_ready;
  assign cfg_ch.valid         = cfg_valid;
  assign cfg_ch.index         = cfg_index;
  assign cfg_ch.data          = cfg_data;

  stop_and_wait_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state and its copy of the registers
  rx_phase_t   m_phase       = RX_IDLE;
  logic [31:0] m_last_seq    = '1;
  logic [31:0] m_bytes       = '0;
  logic [15:0] m_tries       = '0;
  logic [15:0] m_mtu         = MTU_BYTES_RST;
  logic [31:0] m_capacity    = BUFFER_BYTES_RST;
  logic [15:0] m_retry_limit = RETRY_LIMIT_RST;

  rx_event_t  pending_events[$];
  rx_result_t awaited_results[$];

  logic        in_fire      = 1'b0;
  logic        out_fire     = 1'b0;
  logic        idling_on    = 1'b1;
  logic        hold_request = 1'b0;
  logic        hold_taken   = 1'b0;
  int unsigned in_gap       = 0;
  int unsigned out_wait     = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;
  int unsigned events_in    = 0;
  int unsigned results_out  = 0;
  int unsigned reg_writes   = 0;
  int unsigned status_seen[8];

  initial begin
    forever #1 clk = ~clk;
  end

  // one failed attempt; true if the reception gives up
  function automatic logic count_failure();
    m_tries = m_tries + 16'd1;
    if (m_tries >= m_retry_limit) begin
      m_phase = RX_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] add_saturate(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic rx_result_t predict_decision(rx_event_t ev);
    rx_result_t  r;
    logic        basic;
    logic        has_data;
    logic [32:0] sum;
    logic [15:0] stride;
    logic [31:0] off;
    r = '0;
    r.reply_kind = REPLY_NONE;
    r.status = ST_RECEIVING;
    basic = ev.packet_bytes >= HEADER_BYTES && ev.checksum_ok &&
            ev.length_field == ev.packet_bytes - HEADER_BYTES;
    has_data = ev.flags[FLAG_BIT_PSH] | ev.flags[FLAG_BIT_LAST];
    sum = {1'b0, m_bytes} + {17'd0, ev.length_field};
    if (ev.action == ACT_START) begin
      m_phase = RX_FIRST;
      m_last_seq = '1;
      m_bytes = '0;
      m_tries = '0;
    end else if (ev.action == ACT_UNUSED || m_phase == RX_IDLE) begin
      if (m_phase == RX_IDLE) r.status = ST_IDLE;
    end else if (ev.action == ACT_TIMEOUT) begin
      // timeouts only count once the first packet is in
      if (m_phase == RX_ACTIVE && count_failure()) r.status = ST_EXHAUSTED;
    end else if (!ev.source_matches) begin
      r.reply_kind = REPLY_FIN;
    end else if (basic && ev.flags == FLAGS_FIN_ONLY) begin
      r.reply_kind = REPLY_FIN_ACK;
      m_phase = RX_IDLE;
      r.status = ST_CLOSED;
    end else if (!basic || !has_data) begin
      if (count_failure()) r.status = ST_EXHAUSTED;
    end else if (m_phase == RX_FIRST) begin
      m_tries = '0;
      r.reply_kind = REPLY_ACK;
      r.reply_seq = ev.seq_num;
      r.write_enable = 1'b1;
      r.write_length = ({16'd0, ev.length_field} < m_capacity) ? ev.length_field
                                                                : m_capacity[15:0];
      m_bytes = add_saturate(m_bytes, ev.length_field);
      m_last_seq = ev.seq_num;
      if (sum > {1'b0, m_capacity}) begin
        m_phase = RX_IDLE;
        r.status = ST_OVERFLOW;
      end else if (ev.flags[FLAG_BIT_LAST]) begin
        m_phase = RX_IDLE;
        r.status = ST_DONE_LAST;
      end else begin
        m_phase = RX_ACTIVE;
      end
    end else begin
      m_tries = '0;
      r.reply_kind = REPLY_ACK;
      if (ev.seq_num != m_last_seq + 32'd1) begin
        r.reply_seq = m_last_seq;
      end else begin
        stride = (m_mtu > HEADER_BYTES) ? m_mtu - HEADER_BYTES : 16'd0;
        off = ev.seq_num * {16'd0, stride};
        r.write_enable = 1'b1;
        r.write_offset = off;
        if (off >= m_capacity) r.write_length = '0;
        else if ({1'b0, off} + {17'd0, ev.length_field} > {1'b0, m_capacity})
          r.write_length = 16'(m_capacity - off);
        else r.write_length = ev.length_field;
        m_bytes = add_saturate(m_bytes, ev.length_field);
        m_last_seq = ev.seq_num;
        r.reply_seq = ev.seq_num;
        // LAST wins over overflow once past the first packet
        if (ev.flags[FLAG_BIT_LAST]) begin
          m_phase = RX_IDLE;
          r.status = ST_DONE_LAST;
        end else if (sum > {1'b0, m_capacity}) begin
          m_phase = RX_IDLE;
          r.status = ST_OVERFLOW;
        end
      end
    end
    r.byte_total = m_bytes;
    return r;
  endfunction

  function automatic int unsigned next_wait();
    if (!idling_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic rx_event_t random_event();
    rx_event_t   ev;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    ev = raw[$bits(rx_event_t)-1:0];
    return ev;
  endfunction

  function automatic rx_event_t control_event(logic [ACTION_W-1:0] act);
    rx_event_t ev;
    ev = random_event();
    ev.action = act;
    return ev;
  endfunction

  function automatic rx_event_t packet_event(logic [31:0] seq, logic [15:0] len,
                                             logic [FLAGS_W-1:0] fl);
    rx_event_t ev;
    ev.action = ACT_PACKET;
    ev.source_matches = 1'b1;
    ev.packet_bytes = len + HEADER_BYTES;
    ev.length_field = len;
    ev.checksum_ok = 1'b1;
    ev.flags = fl;
    ev.seq_num = seq;
    return ev;
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return MAX_PAYLOAD;
      2, 3:    return 16'($urandom_range(0, MAX_PAYLOAD));
      default: return 16'($urandom_range(1, 1500));
    endcase
  endfunction

  function automatic logic [FLAGS_W-1:0] data_flags();
    logic [FLAGS_W-1:0] fl;
    fl = FL_PSH;
    fl[FLAG_BIT_SYN] = 1'($urandom_range(0, 1));
    fl[FLAG_BIT_ACK] = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0) fl = fl | FL_LAST;
    if ($urandom_range(0, 15) == 0) fl = (fl & ~FL_PSH) | FL_LAST;
    if ($urandom_range(0, 7) == 0) fl = fl | FLAGS_FIN_ONLY;
    return fl;
  endfunction

  // mostly well-formed receptions, salted with duplicates, timeouts, foreign sources, FINs and broken packets
  task automatic queue_random_traffic(int unsigned count);
    rx_event_t   ev;
    logic [31:0] next_seq;
    int unsigned made;
    int unsigned steps;
    int unsigned k;
    made = 0;
    while (made < count) begin
      pending_events.push_back(control_event(ACT_START));
      made++;
      case ($urandom_range(0, 3))
        0:       next_seq = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        1:       next_seq = 32'($urandom_range(0, 10));
        default: next_seq = $urandom;
      endcase
      steps = $urandom_range(4, 40);
      repeat (steps) begin
        k = $urandom_range(0, 99);
        if (k < 62) begin
          ev = packet_event(next_seq, pick_length(), data_flags());
          next_seq++;
        end else if (k < 70) begin
          ev = packet_event($urandom_range(0, 1) ? next_seq - 32'($urandom_range(1, 2))
                                                 : $urandom, pick_length(), data_flags());
        end else if (k < 76) begin
          ev = control_event(ACT_TIMEOUT);
        end else if (k < 81) begin
          ev = control_event(ACT_PACKET);
          ev.source_matches = 1'b0;
        end else if (k < 90) begin
          ev = packet_event(next_seq, pick_length(), data_flags());
          case ($urandom_range(0, 3))
            0:       ev.checksum_ok = 1'b0;
            1:       ev.length_field = ev.length_field ^ (16'd1 << $urandom_range(0, 15));
            2:       ev.packet_bytes = 16'($urandom_range(0, HEADER_BYTES - 1));
            default: ev.flags = ev.flags & ~(FL_PSH | FL_LAST);
          endcase
        end else if (k < 93) begin
          ev = packet_event(next_seq, pick_length(), FLAGS_FIN_ONLY);
        end else if (k < 97) begin
          ev = random_event();
        end else begin
          ev = control_event(ACT_UNUSED);
        end
        pending_events.push_back(ev);
        made++;
      end
    end
  endtask

  task automatic drain_block();
    while (pending_events.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_MTU_BYTES:    m_mtu = value[15:0];
      CFG_BUFFER_BYTES: m_capacity = value;
      CFG_RETRY_LIMIT:  m_retry_limit = value[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(logic [15:0] mtu, logic [31:0] capacity, logic [15:0] retries);
    write_register(CFG_MTU_BYTES, {16'd0, mtu});
    write_register(CFG_BUFFER_BYTES, capacity);
    write_register(CFG_RETRY_LIMIT, {16'd0, retries});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, name, want, got);
      if (errors == MAX_SHOWN) $display("%0t: further mismatches not shown", $time);
    end
  endtask

  // sender: next event at the falling edge, random gap after each transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) in_gap = next_wait();
      if (!in_valid || in_fire) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          in_item  <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs up the input
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (out_fire) out_wait = next_wait();
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_wait != 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predict on accepted events, check accepted results, watch for a hang
  always @(posedge clk) begin : monitor
    rx_result_t want;
    rx_result_t got;
    in_fire  = rst_n && in_valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ready;
    if (in_fire) begin
      want = predict_decision(in_item);
      awaited_results.push_back(want);
      status_seen[want.status]++;
      events_in++;
    end
    if (out_fire) begin
      results_out++;
      got.reply_kind   = out_ch.reply_kind;
      got.reply_seq    = out_ch.reply_seq;
      got.write_enable = out_ch.write_enable;
      got.write_offset = out_ch.write_offset;
      got.write_length = out_ch.write_length;
      got.status       = out_ch.status;
      got.byte_total   = out_ch.byte_total;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with no event pending, expected none actual 0x%h", $time, got);
      end else begin
        want = awaited_results.pop_front();
        compare_field("reply_kind", 32'(want.reply_kind), 32'(got.reply_kind));
        compare_field("reply_seq", want.reply_seq, got.reply_seq);
        compare_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
        compare_field("write_offset", want.write_offset, got.write_offset);
        compare_field("write_length", 32'(want.write_length), 32'(got.write_length));
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("byte_total", want.byte_total, got.byte_total);
      end
    end
    if (in_fire || out_fire || (rst_n && cfg_valid && cfg_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, awaited_results.size());
      $display("stop_and_wait_receiver test failed");
      $finish;
    end
  end

  initial begin : stimulus
    rx_event_t   ev;
    logic [31:0] base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: idle handling, wrap of the sequence, retry exhaustion
    pending_events.push_back(packet_event(32'd5, 16'd100, FL_PSH));
    pending_events.push_back(control_event(ACT_TIMEOUT));
    pending_events.push_back(control_event(ACT_UNUSED));
    pending_events.push_back(control_event(ACT_START));
    pending_events.push_back(control_event(ACT_TIMEOUT));
    pending_events.push_back(control_event(ACT_UNUSED));
    ev = packet_event(32'd7, 16'd20, FL_PSH);
    ev.source_matches = 1'b0;
    pending_events.push_back(ev);
    ev = packet_event(32'd9, 16'd0, FL_PSH);
    ev.packet_bytes = 16'd5;
    pending_events.push_back(ev);
    pending_events.push_back(packet_event(32'hFFFF_FFFE, 16'd100, FL_PSH));
    pending_events.push_back(packet_event(32'hFFFF_FFFE, 16'd100, FL_PSH));
    pending_events.push_back(packet_event(32'hFFFF_FFFF, 16'd0, FL_PSH));
    pending_events.push_back(packet_event(32'd0, 16'd1000, FL_PSH | FL_SYN | FL_ACK));
    pending_events.push_back(packet_event(32'd1, 16'd10, FL_SYN | FL_ACK));
    ev = packet_event(32'd1, 16'd10, FL_PSH);
    ev.checksum_ok = 1'b0;
    pending_events.push_back(ev);
    ev = packet_event(32'd1, 16'd10, FL_PSH);
    ev.length_field = 16'd11;
    pending_events.push_back(ev);
    pending_events.push_back(control_event(ACT_START));
    pending_events.push_back(packet_event(32'd1234, MAX_PAYLOAD, FL_LAST));
    pending_events.push_back(control_event(ACT_START));
    pending_events.push_back(packet_event(32'd50, 16'd64, FL_PSH));
    pending_events.push_back(packet_event(32'd51, 16'd0, FLAGS_FIN_ONLY));
    pending_events.push_back(control_event(ACT_START));
    pending_events.push_back(packet_event(32'd10, 16'd300, FL_PSH));
    pending_events.push_back(packet_event(32'd11, 16'd300, FL_PSH));
    repeat (3) pending_events.push_back(control_event(ACT_TIMEOUT));
    drain_block();

    // smallest settings: empty buffer, one retry
    configure(16'd16, 32'd0, 16'd1);
    pending_events.push_back(control_event(ACT_START));
    pending_events.push_back(packet_event(32'd40, 16'd10, FL_PSH));
    pending_events.push_back(control_event(ACT_START));
    ev = packet_event(32'd40, 16'd10, FL_PSH);
    ev.checksum_ok = 1'b0;
    pending_events.push_back(ev);
    pending_events.push_back(control_event(ACT_START));
    pending_events.push_back(packet_event(32'd3, 16'd0, FL_PSH));
    pending_events.push_back(packet_event(32'd4, 16'd0, FL_LAST));
    drain_block();

    // packet size no larger than the header: every offset collapses to zero
    configure(HEADER_BYTES, 32'd5000, 16'd2);
    pending_events.push_back(control_event(ACT_START));
    pending_events.push_back(packet_event(32'd7, 16'd1000, FL_PSH));
    pending_events.push_back(packet_event(32'd8, 16'd1000, FL_PSH));
    pending_events.push_back(packet_event(32'd9, 16'd3500, FL_PSH));
    drain_block();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(MTU_BYTES_RST, BUFFER_BYTES_RST, RETRY_LIMIT_RST);
        1: configure(16'd16, 32'd0, 16'd1);
        2: configure(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        3: configure(16'd576, 32'd5000, 16'd2);
        4: configure(16'd1024, 32'd200000, 16'd4);
        default: configure(16'($urandom_range(16, 65535)), $urandom,
                           16'($urandom_range(1, 6)));
      endcase
      idling_on = (p != 4);
      if (p == 2) hold_request = 1'b1;
      queue_random_traffic(RANDOM_PER_PHASE);
      drain_block();
    end

    // one long back-to-back reception with the widest settings
    configure(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    idling_on = 1'b0;
    base = $urandom;
    pending_events.push_back(control_event(ACT_START));
    for (int unsigned i = 0; i < LONG_RUN_PACKETS; i++)
      pending_events.push_back(packet_event(base + i, MAX_PAYLOAD, FL_PSH));
    pending_events.push_back(packet_event(base + LONG_RUN_PACKETS, 16'd1, FL_PSH));
    drain_block();

    $display("run: %0d events in, %0d results out, %0d register writes", events_in,
             results_out, reg_writes);
    $display("outcomes: %0d done on LAST, %0d overflow, %0d closed, %0d gave up, %0d ignored",
             status_seen[ST_DONE_LAST], status_seen[ST_OVERFLOW], status_seen[ST_CLOSED],
             status_seen[ST_EXHAUSTED], status_seen[ST_IDLE]);
    if (errors == 0) begin
      $display("stop_and_wait_receiver test passed");
    end else begin
      $display("stop_and_wait_receiver test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/swr_pkg.sv
rtl/core/swr_channels.sv
rtl/core/stop_and_wait_receiver.sv
bench/tb_stop_and_wait_receiver.sv
